/* sv/aebd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aebd_pkg: shared types and constants of the audio energy beat detector
// Holds the sequencer state type, the divide/root unit command and the
// fixed-point constants of the frame metrics.
// ----------------------------------------------------------------------------
package aebd_pkg;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ,
		ST_LP,
		ST_QDIV,
		ST_ROOT,
		ST_BMUL,
		ST_BDIV,
		ST_TMUL,
		ST_TDIV,
		ST_NF1,
		ST_NF2,
		ST_E1,
		ST_E2,
		ST_TH,
		ST_IDIV,
		ST_BP1,
		ST_BP2,
		ST_OUT
	} state_t;

	// Command to the shared divide / square-root unit.
	typedef struct packed {
		logic start;
		logic root;
	} ds_cmd_t;

	// Register indexes, selected by paddr[2].
	localparam logic REG_FRAME_LEN = 1'b0;
	localparam logic REG_COOLDOWN  = 1'b1;

	localparam logic [23:0] ONE_Q23     = 24'd8388608;
	localparam logic [23:0] W_ALPHA     = 24'd2621;
	localparam logic [23:0] W_BAND_GAIN = 24'd144179;
	localparam logic [23:0] W_NF_KEEP   = 24'd65208;
	localparam logic [23:0] W_NF_NEW    = 24'd328;
	localparam logic [23:0] W_ENV_KEEP  = 24'd60293;
	localparam logic [23:0] W_ENV_NEW   = 24'd5243;
	localparam logic [23:0] W_THR       = 24'd15729;
	localparam logic [23:0] W_BPM_KEEP  = 24'd53740;
	localparam logic [23:0] W_BPM_NEW   = 24'd11796;
	localparam logic [24:0] THR_OFFSET  = 25'd754975;
	localparam logic [31:0] MIN_PER_Q16 = 32'd3932160000;
	localparam logic [31:0] GAP_MIN_MS  = 32'd273;
	localparam logic [31:0] GAP_MAX_MS  = 32'd1500;
	localparam logic [23:0] BPM_RESET   = 24'd7864320;

endpackage

/* sv/aebd_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aebd_mul: bit-serial shift-add multiplier
// One multiplier bit per cycle; the product is held until the next start.
// ----------------------------------------------------------------------------
module aebd_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [23:0] b,
	output logic        done,
	output logic [55:0] prod
);

	logic [55:0] mcand_q;
	logic [23:0] mplier_q;
	logic [55:0] acc_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd24;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= {24'd0, a};
			mplier_q <= b;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[54:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[23:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* sv/aebd_divsqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aebd_divsqrt: shared restoring divider and square-root unit
// Division yields one quotient bit per cycle; the root yields one result bit
// per cycle from two operand bits. Both truncate.
// ----------------------------------------------------------------------------
module aebd_divsqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  aebd_pkg::ds_cmd_t cmd,
	input  logic [55:0]       num,
	input  logic [10:0]       den,
	output logic              done,
	output logic [39:0]       res
);

	logic [55:0] sh_q;
	logic [31:0] rem_q;
	logic [27:0] root_q;
	logic [10:0] den_q;
	logic        mode_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [11:0] dtrial_c;
	logic        dge_c;
	logic [31:0] rtrial_c;
	logic [31:0] rsub_c;
	logic        rge_c;

	always_comb begin
		dtrial_c = {rem_q[10:0], sh_q[39]};
		dge_c    = dtrial_c >= {1'b0, den_q};
		rtrial_c = {rem_q[29:0], sh_q[55:54]};
		rsub_c   = {2'b00, root_q, 2'b01};
		rge_c    = rtrial_c >= rsub_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.root ? 6'd28 : 6'd40;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sh_q   <= num;
			rem_q  <= '0;
			root_q <= '0;
			den_q  <= den;
			mode_q <= cmd.root;
		end else if (busy_q) begin
			if (mode_q) begin
				sh_q <= {sh_q[53:0], 2'b00};
				if (rge_c) begin
					rem_q  <= rtrial_c - rsub_c;
					root_q <= {root_q[26:0], 1'b1};
				end else begin
					rem_q  <= rtrial_c;
					root_q <= {root_q[26:0], 1'b0};
				end
			end else begin
				sh_q  <= {sh_q[54:0], dge_c};
				rem_q <= dge_c ? {20'd0, dtrial_c - {1'b0, den_q}} : {20'd0, dtrial_c};
			end
		end
	end

	assign done = done_q;
	assign res  = mode_q ? {12'd0, root_q} : sh_q[39:0];

endmodule

/* sv/audio_energy_beat_detector_unit.sv */
// A sample that does not close a frame passes two serial multiplies before
// the input is ready again. A frame-closing sample adds three divides, a
// root and seven serial multiplies, plus a divide and two multiplies on a
// tempo update.
// One item is worked on at a time; the result sits in an output register.
// Reset is asynchronous and active low; there is no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_energy_beat_detector_unit: frame energy, band level and beat tracker
// Low-pass filters each sample, sums squares and band magnitudes over a
// frame, and at frame end produces energy, bass, treble, tempo and beat.
// ----------------------------------------------------------------------------
module audio_energy_beat_detector_unit #(
	parameter int FRAME_MAX   = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [31:0]                   now_ms,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [15:0]                   energy,
	output logic [15:0]                   bass,
	output logic [15:0]                   treble,
	output logic [15:0]                   tempo,
	output logic                          beat,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// The sample counter never exceeds the clamped frame length, which is
	// also bounded by the 9-bit frame length register.
	localparam int CNT_W = (FRAME_MAX > 511) ? 9 : $clog2(FRAME_MAX + 1);
	localparam logic [9:0] LEN_MAX = (FRAME_MAX > 511) ? 10'd511 : 10'(FRAME_MAX);

	// Configuration registers.
	logic [8:0] frame_len_q;
	logic [9:0] cooldown_q;

	// Sequencer.
	aebd_pkg::state_t state_q, state_d;
	logic issued_q;

	// Persistent detector state.
	logic signed [23:0] lp_q;
	logic [39:0]        sq_sum_q;
	logic [31:0]        bass_sum_q;
	logic [31:0]        treble_sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [23:0]        nf_q;
	logic [23:0]        env_q;
	logic [23:0]        bpm_q;
	logic               beat_seen_q;
	logic [31:0]        last_q;

	// Working registers of the current item.
	logic signed [23:0] x_q;
	logic [31:0]        now_q;
	logic [39:0]        q_q;
	logic [23:0]        rms_q;
	logic [23:0]        bass_lvl_q;
	logic [23:0]        treb_lvl_q;
	logic [41:0]        acc_q;
	logic [23:0]        inst_q;
	logic [10:0]        elapsed_q;
	logic               beat_q;

	// Output register.
	logic        out_valid_q;
	logic [15:0] energy_q;
	logic [15:0] bass_q;
	logic [15:0] treble_q;
	logic [15:0] tempo_q;
	logic        beat_out_q;

	// Serial units.
	logic              mul_start;
	logic [31:0]       mul_a;
	logic [23:0]       mul_b;
	logic              mul_done;
	logic [55:0]       mul_prod;
	aebd_pkg::ds_cmd_t ds_cmd;
	logic [55:0]       ds_num;
	logic [10:0]       ds_den;
	logic              ds_done;
	logic [39:0]       ds_res;

	logic is_mul_state;
	logic is_ds_state;
	logic unit_done;

	aebd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	aebd_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ds_cmd),
		.num    (ds_num),
		.den    (ds_den),
		.done   (ds_done),
		.res    (ds_res)
	);

	// ------------------------------------------------------------------
	// Per-sample arithmetic. The low-pass step rounds half away from zero
	// and saturates to Q1.23; the sums saturate at their register widths.
	// ------------------------------------------------------------------
	logic [23:0]        ax_c;
	logic signed [24:0] d_c;
	logic [24:0]        ad_c;
	logic [20:0]        m_c;
	logic signed [25:0] m_s_c;
	logic signed [25:0] lp_sum_c;
	logic signed [23:0] lp_new_c;
	logic [23:0]        alp_c;
	logic signed [25:0] hp_c;
	logic [24:0]        ahp_c;
	logic [40:0]        sq_add_c;
	logic [32:0]        bass_add_c;
	logic [32:0]        treb_add_c;
	logic [CNT_W:0]     cnt_next_c;
	logic [9:0]         len_c;
	logic               frame_end_c;

	always_comb begin
		ax_c     = x_q[23] ? (~x_q + 24'd1) : x_q;
		d_c      = 25'(x_q) - 25'(lp_q);
		ad_c     = d_c[24] ? 25'(~d_c + 25'd1) : 25'(d_c);
		m_c      = 21'((mul_prod[36:0] + 37'd32768) >> 16);
		m_s_c    = $signed({5'd0, m_c});
		lp_sum_c = d_c[24] ? (26'(lp_q) - m_s_c) : (26'(lp_q) + m_s_c);
		if (lp_sum_c > 26'sd8388607) begin
			lp_new_c = 24'sh7FFFFF;
		end else if (lp_sum_c < -26'sd8388608) begin
			lp_new_c = 24'sh800000;
		end else begin
			lp_new_c = lp_sum_c[23:0];
		end
		alp_c = lp_new_c[23] ? (~lp_new_c + 24'd1) : lp_new_c;
		hp_c  = 26'(x_q) - 26'(lp_new_c);
		ahp_c = hp_c[25] ? 25'(~hp_c + 26'd1) : hp_c[24:0];

		sq_add_c   = {1'b0, sq_sum_q} + {1'b0, mul_prod[55:16]};
		bass_add_c = {1'b0, bass_sum_q} + 33'(alp_c);
		treb_add_c = {1'b0, treble_sum_q} + 33'(ahp_c);

		cnt_next_c = {1'b0, cnt_q} + (CNT_W + 1)'(1);
		if (frame_len_q == 9'd0) begin
			len_c = 10'd1;
		end else if ({1'b0, frame_len_q} > LEN_MAX) begin
			len_c = LEN_MAX;
		end else begin
			len_c = {1'b0, frame_len_q};
		end
		frame_end_c = 10'(cnt_next_c) >= len_c;
	end

	// ------------------------------------------------------------------
	// Frame-end arithmetic.
	// ------------------------------------------------------------------
	logic [23:0] rms_c;
	logic [23:0] lvl_c;
	logic [42:0] blend_c;
	logic [24:0] nf_diff_c;
	logic [28:0] e_raw_c;
	logic [23:0] energy_c;
	logic [23:0] trans_c;
	logic [24:0] thr_c;
	logic [31:0] elapsed_c;
	logic        over_c;
	logic        fire_c;
	logic        range_c;
	logic [16:0] tempo_c;

	always_comb begin
		rms_c = (ds_res[27:0] > 28'(aebd_pkg::ONE_Q23)) ? aebd_pkg::ONE_Q23 : ds_res[23:0];
		lvl_c = (ds_res > 40'(aebd_pkg::ONE_Q23)) ? aebd_pkg::ONE_Q23 : ds_res[23:0];
		// Two weighted terms with half-up rounding; shared by all three smoothers.
		blend_c = {1'b0, acc_q} + 43'(mul_prod[41:0]) + 43'd32768;

		// Energy above the floor, scaled by 7.5 and clamped to one.
		nf_diff_c = {1'b0, rms_q} - {1'b0, nf_q};
		e_raw_c   = ({nf_diff_c, 4'd0} - 29'(nf_diff_c)) >> 1;
		if (rms_q <= nf_q) begin
			energy_c = '0;
		end else if (e_raw_c > 29'(aebd_pkg::ONE_Q23)) begin
			energy_c = aebd_pkg::ONE_Q23;
		end else begin
			energy_c = e_raw_c[23:0];
		end

		trans_c   = (energy_c > env_q) ? (energy_c - env_q) : '0;
		thr_c     = aebd_pkg::THR_OFFSET + 25'((mul_prod[39:0] + 40'd32768) >> 16);
		elapsed_c = now_q - last_q;
		over_c    = !beat_seen_q || (elapsed_c > {22'd0, cooldown_q});
		fire_c    = over_c && ({1'b0, trans_c} > thr_c);
		range_c   = beat_seen_q && (elapsed_c >= aebd_pkg::GAP_MIN_MS)
			&& (elapsed_c <= aebd_pkg::GAP_MAX_MS);

		tempo_c = 17'(({1'b0, bpm_q} + 25'd128) >> 8);
	end

	// Fixed Q.23 level (at most one) to Q0.16 with 65535 as one, rounded.
	function automatic logic [15:0] to_q16(input logic [23:0] v);
		logic [39:0] t;
		begin
			t = {v, 16'd0} - 40'(v) + 40'd4194304;
			return t[38:23];
		end
	endfunction

	// ------------------------------------------------------------------
	// Sequencer: next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			aebd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = aebd_pkg::ST_SQ;
				end
			end
			aebd_pkg::ST_SQ:   if (mul_done) state_d = aebd_pkg::ST_LP;
			aebd_pkg::ST_LP: begin
				if (mul_done) begin
					state_d = frame_end_c ? aebd_pkg::ST_QDIV : aebd_pkg::ST_IDLE;
				end
			end
			aebd_pkg::ST_QDIV: if (ds_done) state_d = aebd_pkg::ST_ROOT;
			aebd_pkg::ST_ROOT: if (ds_done) state_d = aebd_pkg::ST_BMUL;
			aebd_pkg::ST_BMUL: if (mul_done) state_d = aebd_pkg::ST_BDIV;
			aebd_pkg::ST_BDIV: if (ds_done) state_d = aebd_pkg::ST_TMUL;
			aebd_pkg::ST_TMUL: if (mul_done) state_d = aebd_pkg::ST_TDIV;
			aebd_pkg::ST_TDIV: if (ds_done) state_d = aebd_pkg::ST_NF1;
			aebd_pkg::ST_NF1:  if (mul_done) state_d = aebd_pkg::ST_NF2;
			aebd_pkg::ST_NF2:  if (mul_done) state_d = aebd_pkg::ST_E1;
			aebd_pkg::ST_E1:   if (mul_done) state_d = aebd_pkg::ST_E2;
			aebd_pkg::ST_E2:   if (mul_done) state_d = aebd_pkg::ST_TH;
			aebd_pkg::ST_TH: begin
				if (mul_done) begin
					state_d = (fire_c && range_c) ? aebd_pkg::ST_IDIV : aebd_pkg::ST_OUT;
				end
			end
			aebd_pkg::ST_IDIV: if (ds_done) state_d = aebd_pkg::ST_BP1;
			aebd_pkg::ST_BP1:  if (mul_done) state_d = aebd_pkg::ST_BP2;
			aebd_pkg::ST_BP2:  if (mul_done) state_d = aebd_pkg::ST_OUT;
			aebd_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = aebd_pkg::ST_IDLE;
				end
			end
			default: state_d = aebd_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: unit commands and operand selection. Each operation state
	// starts its unit once and waits for the done pulse.
	// ------------------------------------------------------------------
	always_comb begin
		is_mul_state = 1'b0;
		is_ds_state  = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		ds_num       = '0;
		ds_den       = '0;
		ds_cmd.root  = 1'b0;
		case (state_q)
			aebd_pkg::ST_SQ: begin
				is_mul_state = 1'b1;
				mul_a        = 32'(ax_c);
				mul_b        = ax_c;
			end
			aebd_pkg::ST_LP: begin
				is_mul_state = 1'b1;
				mul_a        = 32'(ad_c);
				mul_b        = aebd_pkg::W_ALPHA;
			end
			aebd_pkg::ST_QDIV: begin
				is_ds_state = 1'b1;
				ds_num      = {16'd0, sq_sum_q};
				ds_den      = 11'(cnt_q);
			end
			aebd_pkg::ST_ROOT: begin
				is_ds_state = 1'b1;
				ds_cmd.root = 1'b1;
				ds_num      = {q_q, 16'd0};
			end
			aebd_pkg::ST_BMUL, aebd_pkg::ST_TMUL: begin
				is_mul_state = 1'b1;
				mul_a        = (state_q == aebd_pkg::ST_BMUL) ? bass_sum_q : treble_sum_q;
				mul_b        = aebd_pkg::W_BAND_GAIN;
			end
			aebd_pkg::ST_BDIV, aebd_pkg::ST_TDIV: begin
				is_ds_state = 1'b1;
				ds_num      = {22'd0, mul_prod[49:16]};
				ds_den      = 11'(cnt_q);
			end
			aebd_pkg::ST_NF1: begin
				is_mul_state = 1'b1;
				mul_a        = 32'(nf_q);
				mul_b        = aebd_pkg::W_NF_KEEP;
			end
			aebd_pkg::ST_NF2: begin
				is_mul_state = 1'b1;
				mul_a        = 32'(rms_q);
				mul_b        = aebd_pkg::W_NF_NEW;
			end
			aebd_pkg::ST_E1: begin
				is_mul_state = 1'b1;
				mul_a        = 32'(env_q);
				mul_b        = aebd_pkg::W_ENV_KEEP;
			end
			aebd_pkg::ST_E2: begin
				is_mul_state = 1'b1;
				mul_a        = 32'(energy_c);
				mul_b        = aebd_pkg::W_ENV_NEW;
			end
			aebd_pkg::ST_TH: begin
				is_mul_state = 1'b1;
				mul_a        = 32'(env_q);
				mul_b        = aebd_pkg::W_THR;
			end
			aebd_pkg::ST_IDIV: begin
				is_ds_state = 1'b1;
				ds_num      = {24'd0, aebd_pkg::MIN_PER_Q16 + 32'(elapsed_q[10:1])};
				ds_den      = elapsed_q;
			end
			aebd_pkg::ST_BP1: begin
				is_mul_state = 1'b1;
				mul_a        = 32'(bpm_q);
				mul_b        = aebd_pkg::W_BPM_KEEP;
			end
			aebd_pkg::ST_BP2: begin
				is_mul_state = 1'b1;
				mul_a        = 32'(inst_q);
				mul_b        = aebd_pkg::W_BPM_NEW;
			end
			default: begin
				is_mul_state = 1'b0;
			end
		endcase
		mul_start    = is_mul_state && !issued_q;
		ds_cmd.start = is_ds_state && !issued_q;
		unit_done    = (is_mul_state && mul_done) || (is_ds_state && ds_done);
	end

	// ------------------------------------------------------------------
	// Control and detector state.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= aebd_pkg::ST_IDLE;
			issued_q     <= 1'b0;
			frame_len_q  <= 9'd256;
			cooldown_q   <= 10'd170;
			lp_q         <= '0;
			sq_sum_q     <= '0;
			bass_sum_q   <= '0;
			treble_sum_q <= '0;
			cnt_q        <= '0;
			nf_q         <= '0;
			env_q        <= '0;
			bpm_q        <= aebd_pkg::BPM_RESET;
			beat_seen_q  <= 1'b0;
			last_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (unit_done) begin
				issued_q <= 1'b0;
			end else if (mul_start || ds_cmd.start) begin
				issued_q <= 1'b1;
			end

			if (psel && penable && pwrite) begin
				if (paddr[2] == aebd_pkg::REG_FRAME_LEN) begin
					frame_len_q <= pwdata[8:0];
				end else begin
					cooldown_q <= pwdata[9:0];
				end
			end

			if (state_q == aebd_pkg::ST_SQ && mul_done) begin
				sq_sum_q <= sq_add_c[40] ? '1 : sq_add_c[39:0];
			end

			if (state_q == aebd_pkg::ST_LP && mul_done) begin
				lp_q         <= lp_new_c;
				bass_sum_q   <= bass_add_c[32] ? '1 : bass_add_c[31:0];
				treble_sum_q <= treb_add_c[32] ? '1 : treb_add_c[31:0];
				cnt_q        <= cnt_next_c[CNT_W-1:0];
			end

			if (state_q == aebd_pkg::ST_NF2 && mul_done) begin
				nf_q <= blend_c[39:16];
			end
			if (state_q == aebd_pkg::ST_E2 && mul_done) begin
				env_q <= blend_c[39:16];
			end
			if (state_q == aebd_pkg::ST_BP2 && mul_done) begin
				bpm_q <= blend_c[39:16];
			end

			// The beat decision uses the old beat time; the elapsed gap for the
			// tempo update is captured alongside.
			if (state_q == aebd_pkg::ST_TH && mul_done && fire_c) begin
				beat_seen_q <= 1'b1;
				last_q      <= now_q;
			end

			// The result leaves through the output register; the frame sums
			// restart once it is loaded.
			if (state_q == aebd_pkg::ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q  <= 1'b1;
				sq_sum_q     <= '0;
				bass_sum_q   <= '0;
				treble_sum_q <= '0;
				cnt_q        <= '0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Working values and the output payload.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == aebd_pkg::ST_IDLE && in_valid) begin
			x_q   <= 24'(sample) <<< (24 - SAMPLE_BITS);
			now_q <= now_ms;
		end
		case (state_q)
			aebd_pkg::ST_QDIV: if (ds_done) q_q <= ds_res;
			aebd_pkg::ST_ROOT: if (ds_done) rms_q <= rms_c;
			aebd_pkg::ST_BDIV: if (ds_done) bass_lvl_q <= lvl_c;
			aebd_pkg::ST_TDIV: if (ds_done) treb_lvl_q <= lvl_c;
			aebd_pkg::ST_NF1, aebd_pkg::ST_E1, aebd_pkg::ST_BP1: begin
				if (mul_done) acc_q <= mul_prod[41:0];
			end
			aebd_pkg::ST_TH: begin
				if (mul_done) begin
					beat_q    <= fire_c;
					elapsed_q <= elapsed_c[10:0];
				end
			end
			aebd_pkg::ST_IDIV: if (ds_done) inst_q <= ds_res[23:0];
			aebd_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					energy_q   <= to_q16(energy_c);
					bass_q     <= to_q16(bass_lvl_q);
					treble_q   <= to_q16(treb_lvl_q);
					tempo_q    <= tempo_c[16] ? 16'hFFFF : tempo_c[15:0];
					beat_out_q <= beat_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Ports.
	assign in_stall  = (state_q != aebd_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign energy    = energy_q;
	assign bass      = bass_q;
	assign treble    = treble_q;
	assign tempo     = tempo_q;
	assign beat      = beat_out_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == aebd_pkg::REG_COOLDOWN) ? {22'd0, cooldown_q}
		: {23'd0, frame_len_q};

`ifndef SYNTHESIS
	// The one-shot issue flag is never left set while waiting for a sample.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aebd_pkg::ST_IDLE) |-> !issued_q)
		else $error("issue flag set in idle");

	// A new result only appears from the output state.
	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == aebd_pkg::ST_OUT))
		else $error("result appeared outside the output state");

	// Levels feeding the output conversion stay within one.
	a_levels_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aebd_pkg::ST_OUT) |-> (rms_q <= aebd_pkg::ONE_Q23
		&& bass_lvl_q <= aebd_pkg::ONE_Q23 && nf_q <= aebd_pkg::ONE_Q23))
		else $error("frame level above one");
`endif

endmodule

/* tb/tb_audio_energy_beat_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_energy_beat_detector_unit: self-checking bench of the beat detector
// A queue-fed driver offers audio samples and timestamps, a bit-accurate
// frame-metric predictor builds the expected energy, bass, treble, tempo and
// beat of every closed frame, and a monitor compares each result transaction.
// ----------------------------------------------------------------------------
module tb_audio_energy_beat_detector_unit;

	typedef struct {
		logic signed [15:0] sample;
		logic [31:0]        now_ms;
	} audio_item_t;

	typedef struct {
		logic [15:0] energy;
		logic [15:0] bass;
		logic [15:0] treble;
		logic [15:0] tempo;
		logic        beat;
	} frame_metrics_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] sample = '0;
	logic [31:0] now_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] energy, bass, treble, tempo;
	logic beat;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	audio_item_t    pending_samples[$];
	frame_metrics_t expected_frames[$];
	int errors = 0;

	// Idle percentages of each side; the initial block switches them per phase.
	int send_idle_pct = 10;
	int recv_idle_pct = 63;
	// Long receiver hold-off, counted down in its own process.
	int hold_cycles = 0;
	// Lets the stimulus stop the sender until the block has drained.
	logic send_pause = 1'b0;

	// Copy of the block's configuration and frame state.
	logic [8:0]  cfg_frame_len;
	logic [9:0]  cfg_cooldown;
	longint      lp_q23;
	longint unsigned sq_acc, bass_acc, treble_acc, floor_q23, env_q23, bpm_q16;
	int unsigned frame_fill;
	bit          had_beat;
	logic [31:0] last_beat_ms;

	audio_energy_beat_detector_unit dut (.*);

	always #6 clk = ~clk;

	function automatic longint rnd16(longint v);
		if (v >= 0) return (v + 32768) >>> 16;
		return -((-v + 32768) >>> 16);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned level_q16(longint unsigned v);
		if (v > 64'd8388608) v = 64'd8388608;
		return (v * 65535 + (64'd1 << 22)) >> 23;
	endfunction

	function automatic longint unsigned band_q23(longint unsigned acc, longint unsigned n);
		longint unsigned l;
		l = (acc * 144179) / (n << 16);
		return (l > 64'd8388608) ? 64'd8388608 : l;
	endfunction

	function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
			longint unsigned lim);
		return (a + b > lim) ? lim : a + b;
	endfunction

	// Advance the filter and frame sums by one sample; on a frame close,
	// queue the metrics the block must report.
	task automatic predict_frame_metrics(input logic signed [15:0] s, input logic [31:0] t);
		longint x, hp;
		longint unsigned n, rms, bl, tl, en, tr, thr, inst;
		logic [31:0] gap;
		int unsigned len;
		bit fire;
		frame_metrics_t m;
		x = longint'(s) * 256;
		sq_acc = sat_sum(sq_acc, longint'(x * x) >> 16, (64'd1 << 40) - 1);
		lp_q23 += rnd16((x - lp_q23) * 2621);
		if (lp_q23 > 8388607) lp_q23 = 8388607;
		if (lp_q23 < -8388608) lp_q23 = -8388608;
		hp = x - lp_q23;
		bass_acc = sat_sum(bass_acc, (lp_q23 < 0) ? -lp_q23 : lp_q23, 64'hFFFF_FFFF);
		treble_acc = sat_sum(treble_acc, (hp < 0) ? -hp : hp, 64'hFFFF_FFFF);
		len = cfg_frame_len;
		if (len == 0) len = 1;
		if (len > 256) len = 256;
		frame_fill++;
		if (frame_fill < len) return;
		n = frame_fill;
		rms = int_sqrt((sq_acc / n) << 16);
		if (rms > 64'd8388608) rms = 64'd8388608;
		bl = band_q23(bass_acc, n);
		tl = band_q23(treble_acc, n);
		floor_q23 = (floor_q23 * 65208 + rms * 328 + 32768) >> 16;
		en = 0;
		if (rms > floor_q23) begin
			en = ((rms - floor_q23) * 15) >> 1;
			if (en > 64'd8388608) en = 64'd8388608;
		end
		env_q23 = (env_q23 * 60293 + en * 5243 + 32768) >> 16;
		tr = (en > env_q23) ? en - env_q23 : 0;
		thr = 754975 + ((env_q23 * 15729 + 32768) >> 16);
		gap = t - last_beat_ms;
		fire = (!had_beat || gap > cfg_cooldown) && tr > thr;
		if (fire) begin
			// Only plausible beat intervals (40 to 220 bpm) refine the tempo.
			if (had_beat && gap >= 273 && gap <= 1500) begin
				inst = ((64'd60000 << 16) + gap / 2) / gap;
				bpm_q16 = (bpm_q16 * 53740 + inst * 11796 + 32768) >> 16;
			end
			had_beat = 1'b1;
			last_beat_ms = t;
		end
		m.energy = level_q16(en);
		m.bass = level_q16(bl);
		m.treble = level_q16(tl);
		m.tempo = (((bpm_q16 + 128) >> 8) > 65535) ? 16'hFFFF : 16'((bpm_q16 + 128) >> 8);
		m.beat = fire;
		expected_frames.push_back(m);
		sq_acc = 0;
		bass_acc = 0;
		treble_acc = 0;
		frame_fill = 0;
	endtask

	// Driver: predicts each accepted transaction, then offers the next item.
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			predict_frame_metrics(sample, now_ms);
		if (!in_valid || !in_stall) begin
			if (pending_samples.size() > 0 && !send_pause &&
					$urandom_range(99, 0) >= send_idle_pct) begin
				audio_item_t it;
				it = pending_samples.pop_front();
				sample <= it.sample;
				now_ms <= it.now_ms;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each result transaction against the oldest expectation.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_frames.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				frame_metrics_t e;
				e = expected_frames.pop_front();
				if (energy !== e.energy) begin
					$error("energy: expected %0d, got %0d", e.energy, energy); errors++;
				end
				if (bass !== e.bass) begin
					$error("bass: expected %0d, got %0d", e.bass, bass); errors++;
				end
				if (treble !== e.treble) begin
					$error("treble: expected %0d, got %0d", e.treble, treble); errors++;
				end
				if (tempo !== e.tempo) begin
					$error("tempo: expected %0d, got %0d", e.tempo, tempo); errors++;
				end
				if (beat !== e.beat) begin
					$error("beat: expected %0d, got %0d", e.beat, beat); errors++;
				end
			end
		end
		out_stall <= (hold_cycles > 0) || ($urandom_range(99, 0) < recv_idle_pct);
	end

	// The hold-off counter lives in its own process.
	always @(posedge clk) begin
		if (hold_cycles > 0)
			hold_cycles <= hold_cycles - 1;
	end

	// Register write over the setup/access protocol; only while idle.
	task automatic reg_write(input logic reg_sel, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {reg_sel, 2'b00}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (reg_sel == aebd_pkg::REG_FRAME_LEN) cfg_frame_len = value[8:0];
		else cfg_cooldown = value[9:0];
	endtask

	// Wait for everything queued to be accepted and every result to arrive,
	// then let a frame-closing computation finish in case one is still busy.
	task automatic drain;
		while (pending_samples.size() > 0 || in_valid || expected_frames.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	logic [31:0] clock_ms = 32'd0;

	// One frame-sized burst: loud bursts after quiet ones make transients.
	task automatic queue_frame(input int len, input int amp);
		audio_item_t it;
		for (int i = 0; i < len; i++) begin
			it.sample = 16'($signed($urandom_range(2 * amp, 0)) - amp);
			clock_ms += $urandom_range(3, 0);
			it.now_ms = clock_ms;
			pending_samples.push_back(it);
		end
		clock_ms += $urandom_range(700, 0);
	endtask

	task automatic queue_random(input int count, input int len);
		audio_item_t it;
		for (int i = 0; i < count; i += len) begin
			case ($urandom_range(9, 0))
				0: begin
					// Noise item with any time, wrapping the clock at times.
					it.sample = 16'($urandom);
					clock_ms = $urandom;
					it.now_ms = clock_ms;
					pending_samples.push_back(it);
				end
				1, 2, 3: queue_frame(len, $urandom_range(32767, 12000));
				default: queue_frame(len, $urandom_range(800, 0));
			endcase
		end
	endtask

	initial begin
		audio_item_t it;
		cfg_frame_len = 9'd256;
		cfg_cooldown = 10'd170;
		lp_q23 = 0; sq_acc = 0; bass_acc = 0; treble_acc = 0; frame_fill = 0;
		floor_q23 = 0; env_q23 = 0; bpm_q16 = 64'd120 << 16;
		had_beat = 1'b0; last_beat_ms = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one-sample frames, full-scale extremes, silence, beats
		// at and outside the cooldown, tempo intervals and a wrap.
		reg_write(aebd_pkg::REG_FRAME_LEN, 32'd1);
		reg_write(aebd_pkg::REG_COOLDOWN, 32'd0);
		begin
			logic signed [15:0] dir_s[12];
			int dir_t[12];
			dir_s = '{16'sd0, 16'sd0, 16'sd32767, -16'sd32768,
				16'sd0, 16'sd1, -16'sd1, 16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 16'sd0};
			dir_t = '{0, 10, 100, 100, 300, 310, 320, 400, 700, 900, 1700, 1800};
			foreach (dir_s[i]) begin
				it.sample = dir_s[i]; it.now_ms = dir_t[i];
				pending_samples.push_back(it);
			end
			foreach (dir_s[i]) begin
				it.sample = (i % 3 == 0) ? 16'sh7FFF : 16'sh0000;
				it.now_ms = 32'hFFFF_FE00 + 32'(i * 170);
				pending_samples.push_back(it);
			end
		end
		clock_ms = 32'd2000;
		drain();

		// Zero frame length counts as one; no cooldown; a long receiver hold
		// lets the block back up and stall its input.
		reg_write(aebd_pkg::REG_FRAME_LEN, 32'd0);
		reg_write(aebd_pkg::REG_COOLDOWN, 32'd0);
		queue_random(150, 1);
		hold_cycles = 3000;
		drain();

		send_idle_pct = 63; recv_idle_pct = 10;
		reg_write(aebd_pkg::REG_FRAME_LEN, 32'd4);
		reg_write(aebd_pkg::REG_COOLDOWN, 32'd170);
		queue_random(200, 4);
		// The sender stops mid-phase until every result has come.
		send_pause = 1'b1;
		while (expected_frames.size() > 0 || in_valid) @(posedge clk);
		send_pause = 1'b0;
		drain();

		// Oversize frame length is held at the maximum; largest cooldown.
		reg_write(aebd_pkg::REG_FRAME_LEN, 32'd511);
		reg_write(aebd_pkg::REG_COOLDOWN, 32'd1023);
		queue_frame(256, 20000);
		drain();

		send_idle_pct = 0; recv_idle_pct = 0;
		reg_write(aebd_pkg::REG_FRAME_LEN, 32'd2);
		reg_write(aebd_pkg::REG_COOLDOWN, 32'd1000);
		queue_random(60, 2);
		drain();
		reg_write(aebd_pkg::REG_FRAME_LEN, 32'd3);
		reg_write(aebd_pkg::REG_COOLDOWN, 32'd250);
		queue_random(100, 3);
		drain();

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#200ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
